// File: src/ssmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the spherical shell membership table.
// No dependencies; imported by the top level, the controller, the datapath and the testbench.
package ssmt_pkg;

    localparam int MAX_SHELLS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int BOX_W   = 33;
    localparam int CFG_W   = 5;
    localparam int SQ_W    = 64;
    localparam int RSQ_W   = 2 * RAD_W;
    localparam int WORD_W  = 3 * COORD_W + 2 * RAD_W;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd1;
    localparam logic [OP_W-1:0] OP_BOX   = 2'd2;

    localparam logic KIND_MEMBER = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    typedef struct packed {
        logic store;
        logic start;
        logic issue;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

    function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                                input logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

endpackage

// File: src/spherical_shell_membership_table.sv
`timescale 1ns / 1ps
// Top level of the spherical shell membership table: controller plus datapath.
// Depends on ssmt_pkg, ssmt_ctrl, ssmt_dp, ssmt_ram.
//
//   port group   direction  handshake            payload
//   request      in         i_valid / o_ready    i_operation .. i_radius_out
//   result       out        o_valid / i_ready    o_result_kind .. o_box_z_max
//   config       in         i_cfg_we             i_cfg_data (active_entries)
//
// A write or unused request is accepted without leaving idle, so o_ready stays high.
// A test or box request keeps o_ready low while the controller walks the active
// entries, one store read per entry through the shared squared-distance pipeline,
// drains that pipeline and hands the answer off to the output register.
// With no active entry it skips walk and drain. Synchronous active-low reset clears
// control state; store contents are undefined. A waiting result is held in the
// output register; a stalled query holds in hand-off and keeps o_ready low.
module spherical_shell_membership_table
    import ssmt_pkg::*;
#(
    parameter int MAX_SHELLS = MAX_SHELLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [RAD_W-1:0]          i_radius_in,
    input  logic [RAD_W-1:0]          i_radius_out,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_result_kind,
    output logic                      o_inside_any,
    output logic signed [BOX_W-1:0]   o_box_x_min,
    output logic signed [BOX_W-1:0]   o_box_x_max,
    output logic signed [BOX_W-1:0]   o_box_y_min,
    output logic signed [BOX_W-1:0]   o_box_y_max,
    output logic signed [BOX_W-1:0]   o_box_z_min,
    output logic signed [BOX_W-1:0]   o_box_z_max
);
    localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [AW-1:0] rd_addr;

    ssmt_ctrl #(
        .MAX_SHELLS (MAX_SHELLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    ssmt_dp #(
        .MAX_SHELLS (MAX_SHELLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_radius_in   (i_radius_in),
        .i_radius_out  (i_radius_out),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_inside_any  (o_inside_any),
        .o_box_x_min   (o_box_x_min),
        .o_box_x_max   (o_box_x_max),
        .o_box_y_min   (o_box_y_min),
        .o_box_y_max   (o_box_y_max),
        .o_box_z_min   (o_box_z_min),
        .o_box_z_max   (o_box_z_max)
    );
endmodule

// File: src/ssmt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/ssmt_dp.sv
`timescale 1ns / 1ps
// Datapath: shell store, squared-distance pipeline, box accumulators, result register.
// Depends on ssmt_pkg and ssmt_ram.
module ssmt_dp
    import ssmt_pkg::*;
#(
    parameter int MAX_SHELLS = MAX_SHELLS_DEF,
    localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [AW-1:0]             i_rd_addr,
    output t_dp_sts                   o_sts,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [RAD_W-1:0]          i_radius_in,
    input  logic [RAD_W-1:0]          i_radius_out,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_result_kind,
    output logic                      o_inside_any,
    output logic signed [BOX_W-1:0]   o_box_x_min,
    output logic signed [BOX_W-1:0]   o_box_x_max,
    output logic signed [BOX_W-1:0]   o_box_y_min,
    output logic signed [BOX_W-1:0]   o_box_y_max,
    output logic signed [BOX_W-1:0]   o_box_z_min,
    output logic signed [BOX_W-1:0]   o_box_z_max
);
    logic [31:0]        idx_ext;
    logic               wr_en;
    logic [WORD_W-1:0]  rd_word;
    logic [COORD_W-1:0] cx, cy, cz;
    logic [RAD_W-1:0]   rin, rout;

    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic               r_kind;

    // pipeline valid and first-entry flags
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic r_f0, r_f1;

    logic [COORD_W:0]      dx, dy, dz;
    logic [COORD_W-1:0]    r_dx, r_dy, r_dz;
    logic [RAD_W-1:0]      r_rin1, r_rout1;
    logic signed [BOX_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic signed [BOX_W-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y, r_lo_z, r_hi_z;

    logic [SQ_W-1:0]  r_sqx, r_sqy, r_sqz2, r_sqz3;
    logic [RSQ_W-1:0] r_r0sq2, r_r1sq2, r_r0sq3, r_r1sq3, r_r0sq4, r_r1sq4;
    logic [SQ_W-1:0]  r_sxy, r_d2;

    logic                    r_hit;
    logic signed [BOX_W-1:0] r_ax_lo, r_ax_hi, r_ay_lo, r_ay_hi, r_az_lo, r_az_hi;

    logic                    r_out_valid;
    logic                    r_out_kind;
    logic                    r_out_inside;
    logic signed [BOX_W-1:0] r_ox_lo, r_ox_hi, r_oy_lo, r_oy_hi, r_oz_lo, r_oz_hi;

    assign idx_ext = 32'(i_entry_index);
    assign wr_en   = i_cmd.store && (idx_ext < 32'(MAX_SHELLS));

    ssmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SHELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z, i_radius_in, i_radius_out}),
        .i_re    (i_cmd.issue),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_word)
    );

    assign {cx, cy, cz, rin, rout} = rd_word;

    function automatic logic [COORD_W-1:0] mag(input logic [COORD_W:0] d);
        logic [COORD_W:0] m;
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    assign dx = {cx[COORD_W-1], cx} - {r_px[COORD_W-1], r_px};
    assign dy = {cy[COORD_W-1], cy} - {r_py[COORD_W-1], r_py};
    assign dz = {cz[COORD_W-1], cz} - {r_pz[COORD_W-1], r_pz};

    assign lo_x = $signed({cx[COORD_W-1], cx}) - $signed({2'b00, rout});
    assign hi_x = $signed({cx[COORD_W-1], cx}) + $signed({2'b00, rout});
    assign lo_y = $signed({cy[COORD_W-1], cy}) - $signed({2'b00, rout});
    assign hi_y = $signed({cy[COORD_W-1], cy}) + $signed({2'b00, rout});
    assign lo_z = $signed({cz[COORD_W-1], cz}) - $signed({2'b00, rout});
    assign hi_z = $signed({cz[COORD_W-1], cz}) + $signed({2'b00, rout});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_f0 <= 1'b0;
            r_f1 <= 1'b0;
            r_hit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_f0 <= i_cmd.issue && (i_rd_addr == '0);
            r_v1 <= r_v0;
            r_f1 <= r_f0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.start) begin
                r_hit <= 1'b0;
            end else if (r_v4 && (r_d2 >= SQ_W'(r_r0sq4)) && (r_d2 <= SQ_W'(r_r1sq4))) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px   <= i_coord_x;
            r_py   <= i_coord_y;
            r_pz   <= i_coord_z;
            r_kind <= (i_operation == OP_BOX) ? KIND_BOX : KIND_MEMBER;
        end
        // stage 1: axis distances and cube bounds
        r_dx    <= mag(dx);
        r_dy    <= mag(dy);
        r_dz    <= mag(dz);
        r_rin1  <= rin;
        r_rout1 <= rout;
        r_lo_x  <= lo_x;
        r_hi_x  <= hi_x;
        r_lo_y  <= lo_y;
        r_hi_y  <= hi_y;
        r_lo_z  <= lo_z;
        r_hi_z  <= hi_z;
        // stage 2: squares
        r_sqx   <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqy   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_sqz2  <= SQ_W'(r_dz) * SQ_W'(r_dz);
        r_r0sq2 <= RSQ_W'(r_rin1) * RSQ_W'(r_rin1);
        r_r1sq2 <= RSQ_W'(r_rout1) * RSQ_W'(r_rout1);
        // stage 3 and 4: saturating sum
        r_sxy   <= sat_add(r_sqx, r_sqy);
        r_sqz3  <= r_sqz2;
        r_r0sq3 <= r_r0sq2;
        r_r1sq3 <= r_r1sq2;
        r_d2    <= sat_add(r_sxy, r_sqz3);
        r_r0sq4 <= r_r0sq3;
        r_r1sq4 <= r_r1sq3;
        // union box
        if (i_cmd.start) begin
            r_ax_lo <= '0;
            r_ax_hi <= '0;
            r_ay_lo <= '0;
            r_ay_hi <= '0;
            r_az_lo <= '0;
            r_az_hi <= '0;
        end else if (r_v1) begin
            if (r_f1 || (r_lo_x < r_ax_lo)) r_ax_lo <= r_lo_x;
            if (r_f1 || (r_hi_x > r_ax_hi)) r_ax_hi <= r_hi_x;
            if (r_f1 || (r_lo_y < r_ay_lo)) r_ay_lo <= r_lo_y;
            if (r_f1 || (r_hi_y > r_ay_hi)) r_ay_hi <= r_hi_y;
            if (r_f1 || (r_lo_z < r_az_lo)) r_az_lo <= r_lo_z;
            if (r_f1 || (r_hi_z > r_az_hi)) r_az_hi <= r_hi_z;
        end
        if (i_cmd.load) begin
            r_out_kind   <= r_kind;
            r_out_inside <= (r_kind == KIND_MEMBER) ? r_hit : 1'b0;
            r_ox_lo      <= (r_kind == KIND_BOX) ? r_ax_lo : '0;
            r_ox_hi      <= (r_kind == KIND_BOX) ? r_ax_hi : '0;
            r_oy_lo      <= (r_kind == KIND_BOX) ? r_ay_lo : '0;
            r_oy_hi      <= (r_kind == KIND_BOX) ? r_ay_hi : '0;
            r_oz_lo      <= (r_kind == KIND_BOX) ? r_az_lo : '0;
            r_oz_hi      <= (r_kind == KIND_BOX) ? r_az_hi : '0;
        end
    end

    assign o_sts.busy     = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_inside_any  = r_out_inside;
    assign o_box_x_min   = r_ox_lo;
    assign o_box_x_max   = r_ox_hi;
    assign o_box_y_min   = r_oy_lo;
    assign o_box_y_max   = r_oy_hi;
    assign o_box_z_min   = r_oz_lo;
    assign o_box_z_max   = r_oz_hi;
endmodule

// File: src/ssmt_ctrl.sv
`timescale 1ns / 1ps
// Controller: request handshake, active-entry register, entry walk and result hand-off.
// Depends on ssmt_pkg.
module ssmt_ctrl
    import ssmt_pkg::*;
#(
    parameter int MAX_SHELLS = MAX_SHELLS_DEF,
    localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1,
    localparam int CW = $clog2(MAX_SHELLS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_ready,
    input  logic            i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd,
    output logic [AW-1:0]   o_rd_addr
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ISSUE  = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CFG_W-1:0] r_active;
    logic [CW-1:0]    n_used;
    logic             accept;
    logic             query;

    assign n_used = (32'(r_active) > 32'(MAX_SHELLS)) ? CW'(MAX_SHELLS) : CW'(r_active);
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign query   = (i_operation == OP_TEST) || (i_operation == OP_BOX);
    assign o_rd_addr = r_cnt[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.store = accept && (i_operation == OP_WRITE);
        case (r_state)
            S_IDLE: begin
                if (accept && query) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = (n_used == '0) ? S_FINISH : S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + CW'(1);
                if ((r_cnt + CW'(1)) == n_used) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_active <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.busy)
        else $error("pipeline busy while idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("result loaded over unread result");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_cnt < n_used))
        else $error("entry read beyond active count");

    a_start_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_ISSUE) || (r_state == S_FINISH))
        else $error("query start did not leave idle");
endmodule

// File: test/tb_spherical_shell_membership_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for spherical_shell_membership_table. A scoreboard class
// mirrors the shell table and predicts each answer. Needs ssmt_pkg and the block's RTL.
module tb_spherical_shell_membership_table;
    import ssmt_pkg::*;

    localparam int NUM_SHELLS = MAX_SHELLS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int NUM_PHASES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP = 40;
    localparam longint COORD_MAX = 64'sd2147483647;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [RAD_W-1:0]   r_in;
        logic [RAD_W-1:0]   r_out;
    } t_shell_request;

    typedef struct packed {
        logic             kind;
        logic             hit;
        logic [BOX_W-1:0] x_min;
        logic [BOX_W-1:0] x_max;
        logic [BOX_W-1:0] y_min;
        logic [BOX_W-1:0] y_max;
        logic [BOX_W-1:0] z_min;
        logic [BOX_W-1:0] z_max;
    } t_shell_answer;

    class shell_table_scoreboard;
        logic [COORD_W-1:0] center_x[NUM_SHELLS];
        logic [COORD_W-1:0] center_y[NUM_SHELLS];
        logic [COORD_W-1:0] center_z[NUM_SHELLS];
        logic [RAD_W-1:0]   inner_r[NUM_SHELLS];
        logic [RAD_W-1:0]   outer_r[NUM_SHELLS];
        logic [CFG_W-1:0]   active_cfg;
        t_shell_answer      pending_answers[$];
        int errors, writes, tests, hits, boxes, ignored, checked;

        function new();
            active_cfg = '0;
        endfunction

        function int unsigned used_shells();
            return (active_cfg > NUM_SHELLS) ? NUM_SHELLS : active_cfg;
        endfunction

        function logic [SQ_W-1:0] axis_square(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
            logic signed [COORD_W:0]  diff;
            logic [COORD_W:0]         mag;
            logic [2*COORD_W+1:0]     prod;
            diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
            mag = diff[COORD_W] ? (~diff + 1'b1) : diff;
            prod = {{(COORD_W+1){1'b0}}, mag} * {{(COORD_W+1){1'b0}}, mag};
            return prod[SQ_W-1:0];
        endfunction

        function logic [SQ_W-1:0] add_clamped(logic [SQ_W-1:0] a, logic [SQ_W-1:0] b);
            logic [SQ_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
        endfunction

        function void note_request(t_shell_request r);
            t_shell_answer    ans;
            logic [SQ_W-1:0]  d2, lo_sq, hi_sq;
            longint           lo[3], hi[3], c[3], rad;
            int unsigned      n;
            n = used_shells();
            ans = '0;
            case (r.op)
                OP_WRITE: begin
                    center_x[r.idx] = r.x;
                    center_y[r.idx] = r.y;
                    center_z[r.idx] = r.z;
                    inner_r[r.idx] = r.r_in;
                    outer_r[r.idx] = r.r_out;
                    writes++;
                end
                OP_TEST: begin
                    ans.kind = KIND_MEMBER;
                    for (int i = 0; i < n && !ans.hit; i++) begin
                        d2 = add_clamped(add_clamped(axis_square(r.x, center_x[i]),
                                                     axis_square(r.y, center_y[i])),
                                         axis_square(r.z, center_z[i]));
                        lo_sq = {33'b0, inner_r[i]} * {33'b0, inner_r[i]};
                        hi_sq = {33'b0, outer_r[i]} * {33'b0, outer_r[i]};
                        if (d2 >= lo_sq && d2 <= hi_sq) ans.hit = 1'b1;
                    end
                    tests++;
                    if (ans.hit) hits++;
                    pending_answers.push_back(ans);
                end
                OP_BOX: begin
                    ans.kind = KIND_BOX;
                    for (int i = 0; i < n; i++) begin
                        c[0] = longint'($signed(center_x[i]));
                        c[1] = longint'($signed(center_y[i]));
                        c[2] = longint'($signed(center_z[i]));
                        rad = longint'(outer_r[i]);
                        for (int k = 0; k < 3; k++) begin
                            if (i == 0 || c[k] - rad < lo[k]) lo[k] = c[k] - rad;
                            if (i == 0 || c[k] + rad > hi[k]) hi[k] = c[k] + rad;
                        end
                    end
                    if (n > 0) begin
                        ans.x_min = lo[0][BOX_W-1:0];
                        ans.x_max = hi[0][BOX_W-1:0];
                        ans.y_min = lo[1][BOX_W-1:0];
                        ans.y_max = hi[1][BOX_W-1:0];
                        ans.z_min = lo[2][BOX_W-1:0];
                        ans.z_max = hi[2][BOX_W-1:0];
                    end
                    boxes++;
                    pending_answers.push_back(ans);
                end
                default: ignored++;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_CAP) $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare_box(string name, logic [BOX_W-1:0] got, logic [BOX_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, want %0d", name, $signed(got), $signed(want)));
        endtask

        task check_result(t_shell_answer got);
            t_shell_answer want;
            if (pending_answers.size() == 0) begin
                report("answer arrived with none pending");
            end else begin
                want = pending_answers.pop_front();
                checked++;
                if (got.kind !== want.kind)
                    report($sformatf("result_kind got %b, want %b", got.kind, want.kind));
                if (got.hit !== want.hit)
                    report($sformatf("inside_any got %b, want %b", got.hit, want.hit));
                compare_box("box_x_min", got.x_min, want.x_min);
                compare_box("box_x_max", got.x_max, want.x_max);
                compare_box("box_y_min", got.y_min, want.y_min);
                compare_box("box_y_max", got.y_max, want.y_max);
                compare_box("box_z_min", got.z_min, want.z_min);
                compare_box("box_z_max", got.z_max, want.z_max);
            end
        endtask

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation;
    logic [IDX_W-1:0]          i_entry_index;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic signed [COORD_W-1:0] i_coord_z;
    logic [RAD_W-1:0]          i_radius_in;
    logic [RAD_W-1:0]          i_radius_out;
    logic                      i_cfg_we;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_result_kind;
    logic                      o_inside_any;
    logic signed [BOX_W-1:0]   o_box_x_min;
    logic signed [BOX_W-1:0]   o_box_x_max;
    logic signed [BOX_W-1:0]   o_box_y_min;
    logic signed [BOX_W-1:0]   o_box_y_max;
    logic signed [BOX_W-1:0]   o_box_z_min;
    logic signed [BOX_W-1:0]   o_box_z_max;

    t_shell_request        req_drv;
    t_shell_answer         answer_seen;
    shell_table_scoreboard sb;
    int unsigned           send_idle_pct;
    int unsigned           stall_pct;
    int                    quiet_cycles;
    logic [CFG_W-1:0]      active_plan[NUM_PHASES];

    assign i_operation   = req_drv.op;
    assign i_entry_index = req_drv.idx;
    assign i_coord_x     = req_drv.x;
    assign i_coord_y     = req_drv.y;
    assign i_coord_z     = req_drv.z;
    assign i_radius_in   = req_drv.r_in;
    assign i_radius_out  = req_drv.r_out;
    assign answer_seen = {o_result_kind, o_inside_any, o_box_x_min, o_box_x_max,
                          o_box_y_min, o_box_y_max, o_box_z_min, o_box_z_max};

    spherical_shell_membership_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_radius_in   (i_radius_in),
        .i_radius_out  (i_radius_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_inside_any  (o_inside_any),
        .o_box_x_min   (o_box_x_min),
        .o_box_x_max   (o_box_x_max),
        .o_box_y_min   (o_box_y_min),
        .o_box_y_max   (o_box_y_max),
        .o_box_z_min   (o_box_z_min),
        .o_box_z_max   (o_box_z_max)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_request(req_drv);
            if (o_valid && i_ready) sb.check_result(answer_seen);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("tb_spherical_shell_membership_table: done, errors");
                $finish;
            end
        end
    end

    function automatic t_shell_request make_request(
        logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
        logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
        logic [RAD_W-1:0] r_in, logic [RAD_W-1:0] r_out);
        t_shell_request r;
        r.op = op;
        r.idx = idx;
        r.x = x;
        r.y = y;
        r.z = z;
        r.r_in = r_in;
        r.r_out = r_out;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] v;
        v = $urandom;
        if ($urandom_range(4) != 0) v = {{8{v[23]}}, v[23:0]};
        return v;
    endfunction

    function automatic t_shell_request random_write(logic [IDX_W-1:0] idx);
        logic [RAD_W-1:0] r_in, r_out;
        case ($urandom_range(3))
            0, 1: begin
                r_in = RAD_W'($urandom_range(0, 1 << 22));
                r_out = r_in + RAD_W'($urandom_range(0, 1 << 22));
            end
            2: begin
                r_out = RAD_W'($urandom_range(0, 1 << 22));
                r_in = r_out + RAD_W'($urandom_range(1, 1 << 20));
            end
            default: begin
                r_in = RAD_W'($urandom);
                r_out = RAD_W'($urandom);
            end
        endcase
        return make_request(OP_WRITE, idx, random_coord(), random_coord(), random_coord(),
                            r_in, r_out);
    endfunction

    function automatic t_shell_request random_request();
        t_shell_request     r;
        logic [COORD_W-1:0] ctr[3];
        int unsigned        n, pick, slot, ax;
        longint             t, c, v, r_in, r_out;
        n = sb.used_shells();
        pick = $urandom_range(99);
        r = make_request(OP_TEST, IDX_W'($urandom), $urandom, $urandom, $urandom,
                         RAD_W'($urandom), RAD_W'($urandom));
        if (pick < 25) begin
            slot = (n > 0 && $urandom_range(9) < 7) ? $urandom_range(n - 1)
                                                    : $urandom_range(NUM_SHELLS - 1);
            return random_write(IDX_W'(slot));
        end
        if (pick < 70) begin
            if (n > 0 && $urandom_range(3) != 0) begin
                slot = $urandom_range(n - 1);
                r_in = longint'(sb.inner_r[slot]);
                r_out = longint'(sb.outer_r[slot]);
                case ($urandom_range(5))
                    0: t = r_in;
                    1: t = r_out;
                    2: t = r_out + 1;
                    3: t = (r_in > 0) ? r_in - 1 : 0;
                    4: t = r_in + $urandom_range(0, (r_out > r_in) ? r_out - r_in : 0);
                    default: t = $urandom_range(0, r_out);
                endcase
                ctr[0] = sb.center_x[slot];
                ctr[1] = sb.center_y[slot];
                ctr[2] = sb.center_z[slot];
                ax = $urandom_range(2);
                c = longint'($signed(ctr[ax]));
                v = c + t;
                if (v > COORD_MAX) v = c - t;
                ctr[ax] = v[COORD_W-1:0];
                r.x = ctr[0];
                r.y = ctr[1];
                r.z = ctr[2];
            end
        end else if (pick < 92) begin
            r.op = OP_BOX;
        end else begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic send_request(t_shell_request r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        req_drv = r;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active(logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.active_cfg = value;
    endtask

    initial begin
        int counted;
        t_shell_request r;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        req_drv = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        active_plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd0, 5'd16};
        active_plan[6] = CFG_W'($urandom_range(2, 15));
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table answers, then an ignored operation
        send_request(make_request(OP_TEST, '0, '0, '0, '0, '0, '0));
        send_request(make_request(OP_BOX, '1, '1, '1, '1, '1, '1));
        send_request(make_request(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom,
                                  RAD_W'($urandom), RAD_W'($urandom)));
        send_request(make_request(OP_WRITE, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  '0, 31'h7FFFFFFF));
        send_request(make_request(OP_WRITE, 4'd1, 32'h80000000, 32'h80000000, 32'h80000000,
                                  31'h7FFFFFFF, 31'h7FFFFFFF));
        send_request(make_request(OP_WRITE, 4'd2, 32'h00030000, '0, '0,
                                  31'h00050000, 31'h00010000));
        send_request(make_request(OP_WRITE, 4'd3, '0, '0, '0, '0, '0));
        for (int i = 4; i < NUM_SHELLS; i++) send_request(random_write(IDX_W'(i)));
        wait_drained();
        write_active(CFG_W'(NUM_SHELLS));
        send_request(make_request(OP_TEST, '0, '0, '0, '0, '0, '0));
        send_request(make_request(OP_TEST, '0, 32'h80000000, 32'h80000000, 32'h80000000,
                                  '0, '0));
        send_request(make_request(OP_TEST, '0, '0, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0));
        send_request(make_request(OP_TEST, '0, 32'h00030000, '0, '0, '0, '0));
        send_request(make_request(OP_BOX, '0, '0, '0, '0, '0, '0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_active(active_plan[ph]);
            send_idle_pct = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 29 : 0;
            stall_pct = (ph % 4 == 2) ? 70 : (ph % 4 == 3) ? 29 : 0;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                r = random_request();
                send_request(r);
                counted++;
            end
        end

        wait_drained();
        while (sb.pending() != 0) begin
            void'(sb.pending_answers.pop_front());
            sb.report("expected answer never arrived");
        end
        $display("covered %0d writes, %0d point tests (%0d inside), %0d box queries, %0d ignored",
                 sb.writes, sb.tests, sb.hits, sb.boxes, sb.ignored);
        $display("%0d answers checked across active entry settings 0 to 31, four idle patterns",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("tb_spherical_shell_membership_table: done, clean");
        end else begin
            $display("tb_spherical_shell_membership_table: done, errors");
        end
        $finish;
    end

endmodule
